// ===== hdl/frt_pkg.sv =====
// shared types and constants for the fasta record tokenizer
package frt_pkg;

  localparam logic [7:0] CH_START = 8'h3e;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [2:0] PH_EXPECT    = 3'd0;
  localparam logic [2:0] PH_NAME      = 3'd1;
  localparam logic [2:0] PH_LABEL     = 3'd2;
  localparam logic [2:0] PH_SEQ       = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;
  localparam logic [2:0] PH_ERR_START = 3'd5;
  localparam logic [2:0] PH_ERR_TRUNC = 3'd6;
  localparam logic [2:0] PH_ERR_EMPTY = 3'd7;

  localparam logic [2:0] K_SKIP  = 3'd0;
  localparam logic [2:0] K_START = 3'd1;
  localparam logic [2:0] K_NAME  = 3'd2;
  localparam logic [2:0] K_LABEL = 3'd3;
  localparam logic [2:0] K_LEND  = 3'd4;
  localparam logic [2:0] K_HEND  = 3'd5;
  localparam logic [2:0] K_SEQ   = 3'd6;
  localparam logic [2:0] K_END   = 3'd7;

  localparam logic [1:0] REG_GROUPS_ENABLE  = 2'd0;
  localparam logic [1:0] REG_MARKER_CHAR    = 2'd1;
  localparam logic [1:0] REG_SEPARATOR_CHAR = 2'd2;

  localparam int OUT_DATA_W = 88;

  typedef struct packed {
    logic       end_of_input;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    logic       groups_enable;
    logic [7:0] marker_char;
    logic [7:0] separator_char;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  error_code;
    logic [31:0] line_number;
    logic [7:0]  label_index;
    logic [31:0] sequence_position;
    logic [7:0]  token_byte;
    logic [2:0]  token_kind;
  } result_t;

endpackage

// ===== hdl/frt_in_stage.sv =====
// input register for incoming text words
module frt_in_stage import frt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== hdl/frt_step.sv =====
// parser state and per-byte classification
module frt_step import frt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [2:0]  phase, phase_next;
  logic        label_has_byte, label_has_byte_next;
  logic [31:0] seq_count, seq_count_next;
  logic [7:0]  label_count, label_count_next;
  logic [31:0] line_count, line_count_next;

  logic [7:0]  b;
  logic [2:0]  kind;
  logic [7:0]  tok_byte;
  logic [31:0] pos;
  logic [7:0]  label_mid;
  logic        count_nl;

  assign b = item.text_byte;

  always_comb begin
    phase_next          = phase;
    label_has_byte_next = label_has_byte;
    seq_count_next      = seq_count;
    label_mid           = label_count;
    kind                = K_SKIP;
    tok_byte            = 8'd0;
    pos                 = 32'd0;
    count_nl            = 1'b0;

    if (phase >= PH_DONE) begin
      kind = K_END;
    end else if (item.end_of_input) begin
      kind = K_END;
      phase_next = (phase == PH_NAME || phase == PH_LABEL) ? PH_ERR_TRUNC : PH_DONE;
    end else begin
      unique case (phase)
        PH_EXPECT: begin
          if (b == CH_START) begin
            phase_next          = PH_NAME;
            seq_count_next      = 32'd0;
            label_mid           = 8'd0;
            label_has_byte_next = 1'b0;
            kind                = K_START;
          end else begin
            phase_next = PH_ERR_START;
            kind       = K_END;
          end
        end
        PH_NAME: begin
          if (b == CH_NL) begin
            count_nl   = 1'b1;
            phase_next = PH_SEQ;
            kind       = K_HEND;
          end else if (b == CH_CR) begin
            kind = K_SKIP;
          end else if (cfg.groups_enable && b == cfg.marker_char) begin
            phase_next          = PH_LABEL;
            label_has_byte_next = 1'b0;
            label_mid           = 8'd0;
            kind                = K_SKIP;
          end else begin
            kind     = K_NAME;
            tok_byte = b;
          end
        end
        PH_LABEL: begin
          if (b == CH_CR) begin
            kind = K_SKIP;
          end else if (b == CH_NL || b == cfg.separator_char) begin
            if (!label_has_byte) begin
              phase_next = PH_ERR_EMPTY;
              kind       = K_END;
            end else if (b == CH_NL) begin
              count_nl   = 1'b1;
              phase_next = PH_SEQ;
              kind       = K_HEND;
            end else begin
              kind = K_LEND;
            end
          end else begin
            kind                = K_LABEL;
            tok_byte            = b;
            label_has_byte_next = 1'b1;
          end
        end
        default: begin
          if (b == CH_START) begin
            phase_next          = PH_NAME;
            seq_count_next      = 32'd0;
            label_mid           = 8'd0;
            label_has_byte_next = 1'b0;
            kind                = K_START;
          end else if (b == CH_NL) begin
            count_nl = 1'b1;
            kind     = K_SKIP;
          end else if (b == CH_CR) begin
            kind = K_SKIP;
          end else begin
            kind     = K_SEQ;
            tok_byte = b;
            pos      = seq_count;
            if (seq_count != '1) begin
              seq_count_next = seq_count + 32'd1;
            end
          end
        end
      endcase
    end

    line_count_next = line_count;
    if (count_nl && line_count != '1) begin
      line_count_next = line_count + 32'd1;
    end

    label_count_next = label_mid;
    if (kind == K_LEND) begin
      label_has_byte_next = 1'b0;
      if (label_mid != '1) begin
        label_count_next = label_mid + 8'd1;
      end
    end
  end

  always_comb begin
    res.token_kind        = kind;
    res.token_byte        = tok_byte;
    res.sequence_position = pos;
    res.label_index       = label_mid;
    res.line_number       = line_count_next;
    res.error_code        = (phase_next >= PH_ERR_START) ?
                            2'(phase_next - PH_ERR_START + 3'd1) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_EXPECT;
      label_has_byte <= 1'b0;
      seq_count      <= 32'd0;
      label_count    <= 8'd0;
      line_count     <= 32'd0;
    end else if (advance) begin
      phase          <= phase_next;
      label_has_byte <= label_has_byte_next;
      seq_count      <= seq_count_next;
      label_count    <= label_count_next;
      line_count     <= line_count_next;
    end
  end

endmodule

// ===== hdl/frt_out_stage.sv =====
// result register toward the output stream
module frt_out_stage import frt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res,
  output logic    can_load
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_res <= load_res;
    end
  end

endmodule

// ===== hdl/fasta_record_tokenizer.sv =====
// fasta record tokenizer top level
// an accepted input word is registered in frt_in_stage, then in frt_out_stage
// one word per cycle unless m_tready stalls, set by the state update in frt_step
// s_tready follows m_tready through the input and result registers
// rst (synchronous) clears parser state, counters and valid flags and loads
// the configuration reset values: grouping on, marker '@', separator ','
module fasta_record_tokenizer import frt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // text_byte
  input  logic                  s_tlast,   // end_of_input
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // token_byte, sequence_position, label_index, line_number, error_code, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]            m_tuser,   // token_kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  cfg_t    cfg;
  item_t   in_item, held_item;
  logic    held_valid, can_load, advance;
  result_t step_res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.groups_enable  <= 1'b1;
      cfg.marker_char    <= 8'd64;
      cfg.separator_char <= 8'd44;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GROUPS_ENABLE:  cfg.groups_enable  <= cfg_data[0];
        REG_MARKER_CHAR:    cfg.marker_char    <= cfg_data;
        REG_SEPARATOR_CHAR: cfg.separator_char <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.text_byte    = s_tdata;
  assign in_item.end_of_input = s_tlast;
  assign advance = held_valid && can_load;

  frt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  frt_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .cfg     (cfg),
    .res     (step_res)
  );

  frt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .load_res  (step_res),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .can_load  (can_load)
  );

  assign m_tuser = out_res.token_kind;
  assign m_tdata = {6'd0, out_res.error_code, out_res.line_number, out_res.label_index,
                    out_res.sequence_position, out_res.token_byte};

endmodule
